// File: rtl/tbo_pkg.sv
// tbo_pkg: shared field width for the triangle/box overlap pipeline.
// No dependencies.
package tbo_pkg;
  localparam int unsigned FieldBits = 60;
endpackage

// File: rtl/tbo_front.sv
// tbo_front: unpack, recentre on the box and form the triangle edges.
// Depends on tbo_pkg.
module tbo_front #(
  parameter int unsigned CoordBits = 20
) (
  input  logic [tbo_pkg::FieldBits-1:0] vertex_a_i,
  input  logic [tbo_pkg::FieldBits-1:0] vertex_b_i,
  input  logic [tbo_pkg::FieldBits-1:0] vertex_c_i,
  input  logic [tbo_pkg::FieldBits-1:0] box_center_i,
  input  logic [tbo_pkg::FieldBits-1:0] box_half_extent_i,
  output logic signed [CoordBits+1:0]   v_o [3][3],
  output logic signed [CoordBits+2:0]   e_o [3][3],
  output logic [CoordBits-1:0]          h_o [3]
);
  localparam int unsigned PackBits = 3 * CoordBits;
  localparam int unsigned PadBits  = (PackBits > tbo_pkg::FieldBits) ?
                                     PackBits : tbo_pkg::FieldBits;

  logic [PadBits-1:0] w_s [4];
  logic [PadBits-1:0] h_s;

  always_comb begin
    w_s[0] = PadBits'(vertex_a_i);
    w_s[1] = PadBits'(vertex_b_i);
    w_s[2] = PadBits'(vertex_c_i);
    w_s[3] = PadBits'(box_center_i);
    h_s    = PadBits'(box_half_extent_i);
    for (int q = 0; q < 3; q++) begin
      h_o[q] = h_s[q*CoordBits +: CoordBits];
      for (int i = 0; i < 3; i++) begin
        v_o[i][q] = (CoordBits+2)'($signed(w_s[i][q*CoordBits +: CoordBits]))
                  - (CoordBits+2)'($signed(w_s[3][q*CoordBits +: CoordBits]));
      end
      e_o[0][q] = (CoordBits+3)'(v_o[1][q]) - (CoordBits+3)'(v_o[0][q]);
      e_o[1][q] = (CoordBits+3)'(v_o[2][q]) - (CoordBits+3)'(v_o[1][q]);
      e_o[2][q] = (CoordBits+3)'(v_o[0][q]) - (CoordBits+3)'(v_o[2][q]);
    end
  end
endmodule

// File: rtl/triangle_box_overlap_test_unit.sv
// Triangle/AABB overlap, 13-axis separating axis test, five stage pipeline.
// Depends on tbo_pkg and tbo_front.
//
//   channel | signals                                         | dir
//   request | in_valid_i/in_ready_o, vertex_*_i, box_*_i       | in
//   result  | out_valid_o/out_ready_i, overlaps_o              | out
//
// One request per cycle sustained while the output is not stalled.
// Stages: unpack/edges, products, normal sums/axis compares, plane products,
// plane compare. The stage chain advances whenever the output is free or taken.
// Reset clears valid bits only. A stall freezes every stage together.
module triangle_box_overlap_test_unit #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tbo_pkg::FieldBits-1:0] vertex_a_i,
  input  logic [tbo_pkg::FieldBits-1:0] vertex_b_i,
  input  logic [tbo_pkg::FieldBits-1:0] vertex_c_i,
  input  logic [tbo_pkg::FieldBits-1:0] box_center_i,
  input  logic [tbo_pkg::FieldBits-1:0] box_half_extent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          overlaps_o
);
  localparam int unsigned VB = COORD_BITS + 2;
  localparam int unsigned EB = COORD_BITS + 3;
  localparam int unsigned HB = COORD_BITS;
  localparam int unsigned PB = EB + VB;
  localparam int unsigned SB = PB + 1;
  localparam int unsigned RB = EB + HB + 2;
  localparam int unsigned NB = 2 * EB + 1;
  localparam int unsigned DB = NB + VB + 3;
  localparam int unsigned MB = NB + VB;

  logic adv_s;
  logic [4:0] vld_q, vld_d;

  logic signed [VB-1:0] fv_s [3][3];
  logic signed [EB-1:0] fe_s [3][3];
  logic [HB-1:0]        fh_s [3];

  tbo_front #(.CoordBits(COORD_BITS)) u_front (
    .vertex_a_i, .vertex_b_i, .vertex_c_i, .box_center_i, .box_half_extent_i,
    .v_o(fv_s), .e_o(fe_s), .h_o(fh_s)
  );

  // stage 1 registers
  logic signed [VB-1:0] v1_q [3][3];
  logic signed [EB-1:0] e1_q [3][3];
  logic [HB-1:0]        h1_q [3];

  // stage 2: edge-axis products, normal partial products, box-axis test
  logic signed [PB-1:0] pp_q [3][3][3][2];
  logic signed [RB-2:0] rp_q [3][3][2];
  logic signed [NB-2:0] np_q [3][2];
  logic signed [VB-1:0] v2_q [3][3];
  logic [HB-1:0]        h2_q [3];
  logic                 box_sep_q;

  // stage 3
  logic                 ax_sep_q;
  logic signed [NB-1:0] n3_q [3];
  logic signed [VB-1:0] v3_q [3];
  logic [HB-1:0]        h3_q [3];

  // stage 4
  logic                 sep4_q;
  logic signed [DB-1:0] d4_q;
  logic signed [DB-1:0] r4_q;

  logic                 ovl_q;

  assign adv_s       = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv_s;
  assign out_valid_o = vld_q[4];
  assign overlaps_o  = ovl_q;
  assign vld_d       = {vld_q[3:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_s) begin
      vld_q <= vld_d;
    end
  end

  function automatic logic signed [EB-1:0] abs_e(input logic signed [EB-1:0] x);
    abs_e = x[EB-1] ? -x : x;
  endfunction

  // axis index pairs for edge x X/Y/Z: (a,b) with p = e[a]*v[b] - e[b]*v[a]
  function automatic logic [1:0] ax_a(input int k);
    case (k)
      0: ax_a = 2'd2;
      1: ax_a = 2'd0;
      default: ax_a = 2'd1;
    endcase
  endfunction
  function automatic logic [1:0] ax_b(input int k);
    case (k)
      0: ax_b = 2'd1;
      1: ax_b = 2'd2;
      default: ax_b = 2'd0;
    endcase
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_s) begin
      v1_q <= fv_s;
      e1_q <= fe_s;
      h1_q <= fh_s;
    end
  end

  always_ff @(posedge clk_i) begin
    logic bs;
    logic [1:0] a, b;
    if (adv_s) begin
      bs = 1'b0;
      for (int q = 0; q < 3; q++) begin
        for (int k = 0; k < 3; k++) begin
          a = ax_a(k);
          b = ax_b(k);
          // p[i] = e[a]*v[i][b'] ... axis (edge q) x unit k
          for (int i = 0; i < 3; i++) begin
            pp_q[q][k][i][0] <= PB'(e1_q[q][a]) * PB'(v1_q[i][b]);
            pp_q[q][k][i][1] <= PB'(e1_q[q][b]) * PB'(v1_q[i][a]);
          end
          rp_q[q][k][0] <= (RB-1)'($signed({1'b0, abs_e(e1_q[q][a])}))
                         * (RB-1)'($signed({1'b0, h1_q[b]}));
          rp_q[q][k][1] <= (RB-1)'($signed({1'b0, abs_e(e1_q[q][b])}))
                         * (RB-1)'($signed({1'b0, h1_q[a]}));
        end
        if (((v1_q[0][q] > VB'($signed({1'b0, h1_q[q]}))) &&
             (v1_q[1][q] > VB'($signed({1'b0, h1_q[q]}))) &&
             (v1_q[2][q] > VB'($signed({1'b0, h1_q[q]})))) ||
            ((v1_q[0][q] < -VB'($signed({1'b0, h1_q[q]}))) &&
             (v1_q[1][q] < -VB'($signed({1'b0, h1_q[q]}))) &&
             (v1_q[2][q] < -VB'($signed({1'b0, h1_q[q]})))))
          bs = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        np_q[k][0] <= (NB-1)'(e1_q[0][ax_b(k)]) * (NB-1)'(e1_q[1][ax_a(k)]);
        np_q[k][1] <= (NB-1)'(e1_q[0][ax_a(k)]) * (NB-1)'(e1_q[1][ax_b(k)]);
      end
      box_sep_q <= bs;
      v2_q <= v1_q;
      h2_q <= h1_q;
    end
  end

  // axis order k: X uses (a=2,b=1): p = e2*v1 - e1*v2 ; rad |e2|h1+|e1|h2
  always_ff @(posedge clk_i) begin
    logic sp;
    logic signed [SB-1:0] p0, p1, p2, lo, hi;
    logic signed [RB-1:0] rad;
    if (adv_s) begin
      sp = box_sep_q;
      for (int q = 0; q < 3; q++) begin
        for (int k = 0; k < 3; k++) begin
          p0 = SB'(pp_q[q][k][0][0]) - SB'(pp_q[q][k][0][1]);
          p1 = SB'(pp_q[q][k][1][0]) - SB'(pp_q[q][k][1][1]);
          p2 = SB'(pp_q[q][k][2][0]) - SB'(pp_q[q][k][2][1]);
          rad = RB'(rp_q[q][k][0]) + RB'(rp_q[q][k][1]);
          lo = p0; hi = p0;
          if (p1 < lo) lo = p1;
          if (p1 > hi) hi = p1;
          if (p2 < lo) lo = p2;
          if (p2 > hi) hi = p2;
          if ((SB+1)'(lo) > (SB+1)'(rad) || (SB+1)'(hi) < -(SB+1)'(rad)) sp = 1'b1;
        end
      end
      ax_sep_q <= sp;
      for (int k = 0; k < 3; k++) begin
        n3_q[k] <= NB'(np_q[k][0]) - NB'(np_q[k][1]);
        v3_q[k] <= v2_q[0][k];
      end
      h3_q <= h2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [DB-1:0] d, r;
    logic signed [MB-1:0] pd, pr;
    logic signed [NB-1:0] an;
    if (adv_s) begin
      d = '0;
      r = '0;
      for (int k = 0; k < 3; k++) begin
        an = n3_q[k][NB-1] ? -n3_q[k] : n3_q[k];
        pd = n3_q[k] * v3_q[k];
        pr = an * $signed({1'b0, h3_q[k]});
        d = d + DB'(pd);
        r = r + DB'(pr);
      end
      d4_q   <= d;
      r4_q   <= r;
      sep4_q <= ax_sep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s) begin
      ovl_q <= !sep4_q && ((r4_q + d4_q) >= 0) && ((r4_q - d4_q) >= 0);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlaps_o))
    else $error("result changed during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready mismatch");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost");
endmodule
